// File: sv/assert_macros.svh
// Assertion macros for the sorted integer set RTL.
// No dependencies; included by sis_ctrl, the module that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SIS_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sorted set: same-cycle check failed");
`define SIS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sorted set: next-cycle check failed");
`else
`define SIS_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define SIS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: sv/sis_pkg.sv
// Package of the sorted integer set: codes, field widths, result struct and helpers.
// No dependencies; imported by the controller and the top level.
package sis_pkg;

   localparam int DEFAULT_CAPACITY = 256;
   localparam int VALUE_W          = 64;
   localparam int INDEX_W          = 8;
   localparam int COUNT_OUT_W      = 9;

   localparam logic signed [VALUE_W-1:0] FIT16_HI = 64'sd32767;
   localparam logic signed [VALUE_W-1:0] FIT16_LO = -64'sd32768;
   localparam logic signed [VALUE_W-1:0] FIT32_HI = 64'sd2147483647;
   localparam logic signed [VALUE_W-1:0] FIT32_LO = -64'sd2147483648;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_FIND   = 2'd2,
      OP_READ   = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      WIDTH_16 = 2'd0,
      WIDTH_32 = 2'd1,
      WIDTH_64 = 2'd2
   } width_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_SRCH,
      ST_SRCH_CMP,
      ST_DECIDE,
      ST_SHIFT,
      ST_INS_PUT,
      ST_RD_WAIT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                      ok;
      logic                      full_res;
      logic signed [VALUE_W-1:0] read_value;
      logic [COUNT_OUT_W-1:0]    count;
      width_type                 width_code;
   } result_type;

   // Smallest element width that holds the value.
   function automatic width_type width_of(input logic signed [VALUE_W-1:0] v);
      width_type w;
      if (v >= FIT16_LO && v <= FIT16_HI) begin
         w = WIDTH_16;
      end else if (v >= FIT32_LO && v <= FIT32_HI) begin
         w = WIDTH_32;
      end else begin
         w = WIDTH_64;
      end
      return w;
   endfunction

endpackage

// File: sv/sorted_integer_set.sv
// Top level of the sorted integer set: entry RAM, sequencer and result register.
// Depends on sis_pkg, sis_ram and sis_ctrl.
//
//   channel  direction  handshake            payload
//   req_     in         req_valid/req_stall  opcode, value, index
//   rsp_     out        rsp_valid/rsp_stall  ok, full_res, read_value, count, width_code
//
// One item is worked on at a time. A search step issues the RAM read of the middle entry
// in ST_SRCH and compares the entry in ST_SRCH_CMP. Insert and remove then shift the
// later entries, one entry a cycle. Reset clears the state, the count, the width, the
// shift flags and the output valid flag, not the entry RAM; entry RAM positions at or above
// the count are never read. A stalled result waits in the output register while the next
// item is already being taken in and worked on.
module sorted_integer_set #(
   parameter int CAPACITY = sis_pkg::DEFAULT_CAPACITY
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [1:0]                             req_opcode,
   input  logic signed [sis_pkg::VALUE_W-1:0]     req_value,
   input  logic [sis_pkg::INDEX_W-1:0]            req_index,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_ok,
   output logic                                   rsp_full_res,
   output logic signed [sis_pkg::VALUE_W-1:0]     rsp_read_value,
   output logic [sis_pkg::COUNT_OUT_W-1:0]        rsp_count,
   output logic [1:0]                             rsp_width_code
);
   import sis_pkg::*;

   localparam int AW = $clog2(CAPACITY);

   // Sequencer to RAM.
   logic               ram_wr_en;
   logic [AW-1:0]      ram_wr_addr;
   logic [VALUE_W-1:0] ram_wr_data;
   logic               ram_rd_en;
   logic [AW-1:0]      ram_rd_addr;
   logic [VALUE_W-1:0] ram_rd_data;

   // Finished item from the sequencer, taken when the output register is free.
   logic       res_valid;
   logic       res_take;
   result_type res;

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, rsp_in;

   sis_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   sis_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_opcode  (req_opcode),
      .req_value   (req_value),
      .req_index   (req_index),
      .res_valid   (res_valid),
      .res_take    (res_take),
      .res         (res),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   // The output register is free when empty or when its item leaves this cycle.
   assign res_take = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_take) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_in = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ok         = rsp_ff.ok;
   assign rsp_full_res   = rsp_ff.full_res;
   assign rsp_read_value = rsp_ff.read_value;
   assign rsp_count      = rsp_ff.count;
   assign rsp_width_code = rsp_ff.width_code;

endmodule

// File: sv/sis_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies; used for the entry store.
module sis_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/sis_ctrl.sv
// Sequencer of the sorted integer set: binary search, entry shifting and register state.
// Depends on sis_pkg and assert_macros.svh; drives the ports of one sis_ram.
`include "assert_macros.svh"
module sis_ctrl #(
   parameter int CAPACITY = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_opcode,
   input  logic signed [sis_pkg::VALUE_W-1:0]   req_value,
   input  logic [sis_pkg::INDEX_W-1:0]          req_index,
   output logic                                 res_valid,
   input  logic                                 res_take,
   output sis_pkg::result_type                  res,
   output logic                                 ram_wr_en,
   output logic [$clog2(CAPACITY)-1:0]          ram_wr_addr,
   output logic [sis_pkg::VALUE_W-1:0]          ram_wr_data,
   output logic                                 ram_rd_en,
   output logic [$clog2(CAPACITY)-1:0]          ram_rd_addr,
   input  logic [sis_pkg::VALUE_W-1:0]          ram_rd_data
);
   import sis_pkg::*;

   localparam int AW  = $clog2(CAPACITY);
   localparam int CW  = $clog2(CAPACITY + 1);
   localparam int SW  = CW + 1;
   localparam int IXW = (CW > INDEX_W) ? CW : INDEX_W;
   localparam int XW  = (CW > COUNT_OUT_W) ? CW : COUNT_OUT_W;

   state_type                 state_ff, state_in;
   opcode_type                op_ff, op_in;
   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic [INDEX_W-1:0]        index_ff, index_in;
   width_type                 need_ff, need_in;
   width_type                 width_ff, width_in;
   logic [CW-1:0]             count_ff, count_in;
   logic [CW-1:0]             lo_ff, lo_in;
   logic [CW-1:0]             hi_ff, hi_in;
   logic [AW-1:0]             mid_ff, mid_in;
   logic                      found_ff, found_in;
   logic [CW-1:0]             pos_ff, pos_in;
   logic [AW-1:0]             src_ff, src_in;
   logic [AW-1:0]             dst_ff, dst_in;
   logic [CW-1:0]             moves_ff, moves_in;
   logic                      pend_ff, pend_in;
   logic                      ok_ff, ok_in;
   logic                      full_ff, full_in;
   logic [VALUE_W-1:0]        rdata_ff, rdata_in;

   logic [SW-1:0]             mid_sum;
   logic [IXW-1:0]            idx_ext;
   logic [IXW-1:0]            cnt_ix;
   logic [XW-1:0]             cnt_ext;
   logic                      shift_done;
   logic                      entry_lt;
   logic                      entry_gt;

   assign mid_sum    = SW'(lo_ff) + SW'(hi_ff);
   assign idx_ext    = IXW'(index_ff);
   assign cnt_ix     = IXW'(count_ff);
   assign cnt_ext    = XW'(count_ff);
   assign shift_done = (moves_ff == '0) && !pend_ff;
   assign entry_lt   = $signed(ram_rd_data) < value_ff;
   assign entry_gt   = $signed(ram_rd_data) > value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         width_ff <= WIDTH_16;
         pend_ff  <= 1'b0;
         moves_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         width_ff <= width_in;
         pend_ff  <= pend_in;
         moves_ff <= moves_in;
      end
      op_ff    <= op_in;
      value_ff <= value_in;
      index_ff <= index_in;
      need_ff  <= need_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      mid_ff   <= mid_in;
      found_ff <= found_in;
      pos_ff   <= pos_in;
      src_ff   <= src_in;
      dst_ff   <= dst_in;
      ok_ff    <= ok_in;
      full_ff  <= full_in;
      rdata_ff <= rdata_in;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            unique case (op_ff)
               OP_READ: begin
                  state_in = (idx_ext < cnt_ix) ? ST_RD_WAIT : ST_DONE;
               end
               OP_INSERT: begin
                  state_in = (need_ff > width_ff) ? ST_DECIDE : ST_SRCH;
               end
               default: begin
                  state_in = (need_ff > width_ff) ? ST_DONE : ST_SRCH;
               end
            endcase
         end
         ST_SRCH: begin
            state_in = (lo_ff < hi_ff) ? ST_SRCH_CMP : ST_DECIDE;
         end
         ST_SRCH_CMP: begin
            state_in = (entry_lt || entry_gt) ? ST_SRCH : ST_DECIDE;
         end
         ST_DECIDE: begin
            unique case (op_ff)
               OP_INSERT: begin
                  if (found_ff || count_ff >= CW'(CAPACITY)) begin
                     state_in = ST_DONE;
                  end else begin
                     state_in = ST_SHIFT;
                  end
               end
               OP_REMOVE: begin
                  state_in = found_ff ? ST_SHIFT : ST_DONE;
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_SHIFT: begin
            if (shift_done) begin
               state_in = (op_ff == OP_INSERT) ? ST_INS_PUT : ST_DONE;
            end
         end
         ST_INS_PUT: begin
            state_in = ST_DONE;
         end
         ST_RD_WAIT: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath, memory port and result.
   always_comb begin
      op_in       = op_ff;
      value_in    = value_ff;
      index_in    = index_ff;
      need_in     = need_ff;
      width_in    = width_ff;
      count_in    = count_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      mid_in      = mid_ff;
      found_in    = found_ff;
      pos_in      = pos_ff;
      src_in      = src_ff;
      dst_in      = dst_ff;
      moves_in    = moves_ff;
      pend_in     = pend_ff;
      ok_in       = ok_ff;
      full_in     = full_ff;
      rdata_in    = rdata_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = dst_ff;
      ram_wr_data = ram_rd_data;
      ram_rd_en   = 1'b0;
      ram_rd_addr = mid_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in    = opcode_type'(req_opcode);
               value_in = req_value;
               index_in = req_index;
               need_in  = width_of(req_value);
            end
         end
         ST_START: begin
            ok_in    = 1'b0;
            full_in  = 1'b0;
            rdata_in = '0;
            lo_in    = '0;
            hi_in    = count_ff;
            if (op_ff == OP_READ) begin
               ram_rd_en   = idx_ext < cnt_ix;
               ram_rd_addr = idx_ext[AW-1:0];
            end else if (op_ff == OP_INSERT && need_ff > width_ff) begin
               // Wider than anything stored: negatives go first, the rest last.
               found_in = 1'b0;
               pos_in   = value_ff[VALUE_W-1] ? '0 : count_ff;
            end
         end
         ST_SRCH: begin
            if (lo_ff < hi_ff) begin
               mid_in      = mid_sum[AW:1];
               ram_rd_en   = 1'b1;
               ram_rd_addr = mid_sum[AW:1];
            end else begin
               found_in = 1'b0;
               pos_in   = lo_ff;
            end
         end
         ST_SRCH_CMP: begin
            if (entry_lt) begin
               lo_in = CW'(mid_ff) + CW'(1);
            end else if (entry_gt) begin
               hi_in = CW'(mid_ff);
            end else begin
               found_in = 1'b1;
               pos_in   = CW'(mid_ff);
            end
         end
         ST_DECIDE: begin
            pend_in = 1'b0;
            unique case (op_ff)
               OP_INSERT: begin
                  if (!found_ff) begin
                     if (count_ff >= CW'(CAPACITY)) begin
                        full_in = 1'b1;
                     end else begin
                        if (need_ff > width_ff) begin
                           width_in = need_ff;
                        end
                        src_in   = AW'(count_ff - CW'(1));
                        moves_in = count_ff - pos_ff;
                     end
                  end
               end
               OP_REMOVE: begin
                  src_in   = AW'(pos_ff + CW'(1));
                  moves_in = count_ff - pos_ff - CW'(1);
               end
               default: begin
                  ok_in = found_ff;
               end
            endcase
         end
         ST_SHIFT: begin
            // Read one entry and write back the one read in the cycle before.
            ram_rd_addr = src_ff;
            ram_wr_en   = pend_ff;
            if (moves_ff != '0) begin
               ram_rd_en = 1'b1;
               pend_in   = 1'b1;
               moves_in  = moves_ff - CW'(1);
               if (op_ff == OP_INSERT) begin
                  dst_in = src_ff + AW'(1);
                  src_in = src_ff - AW'(1);
               end else begin
                  dst_in = src_ff - AW'(1);
                  src_in = src_ff + AW'(1);
               end
            end else begin
               pend_in = 1'b0;
            end
            if (shift_done && op_ff == OP_REMOVE) begin
               count_in = count_ff - CW'(1);
               ok_in    = 1'b1;
            end
         end
         ST_INS_PUT: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = pos_ff[AW-1:0];
            ram_wr_data = value_ff;
            count_in    = count_ff + CW'(1);
            ok_in       = 1'b1;
         end
         ST_RD_WAIT: begin
            ok_in    = 1'b1;
            rdata_in = ram_rd_data;
         end
         ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   assign req_stall      = state_ff != ST_IDLE;
   assign res_valid      = state_ff == ST_DONE;
   assign res.ok         = ok_ff;
   assign res.full_res   = full_ff;
   assign res.read_value = rdata_ff;
   assign res.count      = cnt_ext[COUNT_OUT_W-1:0];
   assign res.width_code = width_ff;

   `SIS_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(CAPACITY))
   `SIS_ASSERT_IMPLY(a_shift_no_overlap, clock, reset, ram_wr_en && ram_rd_en, ram_wr_addr != ram_rd_addr)
   `SIS_ASSERT_NEXT(a_width_monotone, clock, reset, !reset, width_ff >= $past(width_ff))
   `SIS_ASSERT_IMPLY(a_shift_op, clock, reset, state_ff == ST_SHIFT, op_ff == OP_INSERT || op_ff == OP_REMOVE)
   `SIS_ASSERT_IMPLY(a_full_only_insert, clock, reset, res_valid && full_ff, op_ff == OP_INSERT && !ok_ff)

endmodule
